@@ sv/drac_pkg.sv @@
// shared types, constants and calendar helpers for the dst rule check
package drac_pkg;

  localparam int unsigned NowW    = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 21;
  localparam int unsigned DayW    = 16;   // signed day number range
  localparam int unsigned YearW   = 12;   // years 1901..2038 fit easily signed
  localparam int unsigned StatusW = 2;

  localparam logic [CfgIdxW-1:0] RegRuleEnabled = 3'd0;
  localparam logic [CfgIdxW-1:0] RegStartDate   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegStartTod    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegEndDate     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegEndTod      = 3'd4;
  localparam logic [CfgIdxW-1:0] RegStdOffset   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDstOffset   = 3'd6;

  localparam logic [StatusW-1:0] StInactive = 2'd0;
  localparam logic [StatusW-1:0] StActive   = 2'd1;
  localparam logic [StatusW-1:0] StNoRule   = 2'd2;

  localparam logic [9:0]  ResetStartDate = 10'd35;
  localparam logic [9:0]  ResetEndDate   = 10'd27;
  localparam logic [20:0] ResetTod       = 21'd7200;

  // days from 1901-01-01 to 1970-01-01, and the same span in seconds
  localparam logic signed [16:0] EpochDays     = 17'sd25202;
  localparam logic [33:0]        EpochShiftSec = 34'd2177452800;
  // ceil(2^36 / 675): exact floor for numerators below 2^26
  localparam logic [26:0]        DayRecip      = 27'd101806633;
  // ceil(2^29 / 1461): exact floor for numerators below 2^18
  localparam logic [18:0]        YearRecip     = 19'd367469;
  localparam logic signed [YearW-1:0] FirstYear = 12'sd1901;

  // cumulative days before each month, non-leap
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      default: r = 9'd334;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    case (m)
      4'd2:    r = leap ? 5'd29 : 5'd28;
      4'd4:    r = 5'd30;
      4'd6:    r = 5'd30;
      4'd9:    r = 5'd30;
      4'd11:   r = 5'd30;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

  // decoded date rule with out-of-range codes folded
  typedef struct packed {
    logic [3:0] month;
    logic [2:0] week;
    logic [2:0] wday;
  } rule_t;

  function automatic rule_t fold_rule(input logic [9:0] r);
    rule_t o;
    o.month = (r[3:0] == 4'd0) ? 4'd1 : ((r[3:0] > 4'd12) ? 4'd12 : r[3:0]);
    o.week  = (r[6:4] == 3'd0) ? 3'd1 : ((r[6:4] > 3'd5) ? 3'd5 : r[6:4]);
    o.wday  = (r[9:7] == 3'd7) ? 3'd0 : r[9:7];
    return o;
  endfunction

  // unsigned value mod 7 by summing octal digits, since 8 is 1 mod 7
  function automatic logic [2:0] mod7u(input logic [8:0] x);
    logic [4:0] s;
    logic [3:0] t;
    s = {2'd0, x[8:6]} + {2'd0, x[5:3]} + {2'd0, x[2:0]};
    t = {2'd0, s[4:3]} + {1'b0, s[2:0]};
    return (t >= 4'd7) ? 3'(t - 4'd7) : t[2:0];
  endfunction

endpackage

@@ sv/drac_if.sv @@
// valid/ready channel carrying one item
interface drac_if #(parameter int unsigned W = 32) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/drac_instant.sv @@
// transition instant for one rule: registered rule day number, then utc second
module drac_instant import drac_pkg::*; (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [YearW-1:0]   year_i,
  input  logic                      leap_i,
  input  logic signed [DayW-1:0]    jan1_i,
  input  logic [2:0]                jan1_wd_i,
  input  rule_t                     rule_i,
  input  logic signed [20:0]        tod_i,
  input  logic signed [17:0]        off_i,
  output logic signed [NowW-1:0]    inst_o
);
  logic signed [DayW+1:0] day_d, day_q;
  logic signed [21:0]     adj_d, adj_q;
  logic [8:0]  doy;
  logic [3:0]  wd_sum;
  logic [2:0]  fwd;
  logic [2:0]  delta;
  logic [5:0]  mday;
  logic signed [DayW+1:0] first;

  // mday of the rule day from the weekday of the first of the month
  always_comb begin
    doy    = month_start(rule_i.month) +
             ((leap_i && rule_i.month > 4'd2) ? 9'd1 : 9'd0);
    first  = {{2{jan1_i[DayW-1]}}, jan1_i} + $signed({9'd0, doy});
    wd_sum = {1'b0, jan1_wd_i} + {1'b0, mod7u(doy)};
    fwd    = (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd7) : wd_sum[2:0];
    delta  = (rule_i.wday >= fwd) ? 3'(rule_i.wday - fwd) : 3'(rule_i.wday + 3'd7 - fwd);
    mday   = 6'd1 + {3'd0, delta} + ({3'd0, rule_i.week} - 6'd1) * 6'd7;
    if (mday > {1'b0, month_len(rule_i.month, leap_i)}) mday = mday - 6'd7;
    day_d  = first + $signed({12'd0, mday}) - 18'sd1;
    adj_d  = 22'(tod_i) + 22'(off_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      day_q <= day_d;
      adj_q <= adj_d;
    end
  end

  // day times 86400 plus adjustments, wrapped to 32 bits
  logic signed [39:0] full;
  assign full   = 40'(day_q) * 40'sd86400 + 40'(adj_q);
  assign inst_o = full[NowW-1:0];
  logic unused_year;
  assign unused_year = ^year_i;
endmodule

@@ sv/dst_rule_active_check.sv @@
// top level: dst rule evaluation pipeline
//
// Input channel in carries now_seconds (signed utc seconds), output channel
// out carries dst_status: 0 inactive, 1 active, 2 no rule.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 enable, 1 start rule, 2 start time, 3 end rule, 4 end time,
// 5 standard offset, 6 daylight offset); write only while idle.
// Pipeline of five register stages: day number, year index, calendar
// base, rule day, instant multiply; the compare sits at the output.
// Each item passes through the stages in order and then shows on out;
// one item per cycle back to back while out does not stall.
// The stages advance together; when the receiver stalls with the last
// stage full the whole pipeline holds and in.ready drops, so no item is
// lost or repeated. Reset empties the pipeline and loads the default
// rule set (disabled, second Sunday of March to first Sunday of
// November at 02:00).
module dst_rule_active_check import drac_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  drac_if.sink                 in,
  drac_if.source               out,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgW-1:0]      cfg_data_i
);
  // configuration registers
  logic        en_q;
  logic [9:0]  sdate_q, edate_q;
  logic [20:0] stod_q, etod_q;
  logic [17:0] soff_q, doff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0; sdate_q <= ResetStartDate; edate_q <= ResetEndDate;
      stod_q <= ResetTod; etod_q <= ResetTod; soff_q <= '0; doff_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegRuleEnabled: en_q    <= cfg_data_i[0];
        RegStartDate:   sdate_q <= cfg_data_i[9:0];
        RegStartTod:    stod_q  <= cfg_data_i;
        RegEndDate:     edate_q <= cfg_data_i[9:0];
        RegEndTod:      etod_q  <= cfg_data_i;
        RegStdOffset:   soff_q  <= cfg_data_i[17:0];
        RegDstOffset:   doff_q  <= cfg_data_i[17:0];
        default: ;
      endcase
    end
  end

  // pipeline control: all stages move when the last can drain
  logic [4:0] v_q;
  logic       adv;
  assign adv      = !v_q[4] || out.ready;
  assign in.ready = adv;
  assign out.valid = v_q[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (adv) v_q <= {v_q[3:0], in.valid};
  end

  // stage 1: days since 1901-01-01 by reciprocal multiply of the shifted seconds
  logic signed [NowW-1:0] now1_q, now2_q, now3_q, now4_q, now5_q;
  logic [15:0] e1_q;
  logic [33:0] secs_d;
  logic [52:0] dprod_d;
  assign secs_d  = {{2{in.data[NowW-1]}}, in.data} + EpochShiftSec;
  assign dprod_d = 53'(secs_d[32:7]) * 53'(DayRecip);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      now1_q <= $signed(in.data);
      e1_q   <= dprod_d[51:36];
    end
  end

  // stage 2: year index from 1901, exact four-year cycle up to 2099
  logic [7:0]  yo2_q;
  logic [36:0] yprod_d;
  assign yprod_d = 37'({e1_q, 2'b11}) * 37'(YearRecip);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      now2_q <= now1_q;
      yo2_q  <= yprod_d[36:29];
    end
  end

  // stage 3: january first of that year, its weekday and leap flag
  logic signed [YearW-1:0] year_d, year3_q;
  logic signed [DayW-1:0]  jan_d, jan3_q;
  logic                    leap_d, leap3_q;
  logic [2:0]              jwd_d, jwd3_q;
  logic [16:0]             jan_e;
  logic [8:0]              wd_idx;
  always_comb begin
    jan_e  = 17'(yo2_q) * 17'd365 + 17'(yo2_q[7:2]);
    jan_d  = DayW'($signed(jan_e) - EpochDays);
    // 1901-01-01 was a tuesday and 365 is 1 mod 7
    wd_idx = 9'd2 + 9'(yo2_q) + 9'(yo2_q[7:2]);
    jwd_d  = mod7u(wd_idx);
    leap_d = (yo2_q[1:0] == 2'b11);
    year_d = $signed({4'd0, yo2_q}) + FirstYear;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      now3_q <= now2_q; year3_q <= year_d; leap3_q <= leap_d;
      jan3_q <= jan_d;  jwd3_q  <= jwd_d;
    end
  end

  // stages 4 and 5: transition instants
  logic signed [NowW-1:0] st_inst, en_inst;
  drac_instant u_start (
    .clk_i, .en_i(adv), .year_i(year3_q), .leap_i(leap3_q), .jan1_i(jan3_q),
    .jan1_wd_i(jwd3_q), .rule_i(fold_rule(sdate_q)), .tod_i(stod_q),
    .off_i(soff_q), .inst_o(st_inst));
  drac_instant u_end (
    .clk_i, .en_i(adv), .year_i(year3_q), .leap_i(leap3_q), .jan1_i(jan3_q),
    .jan1_wd_i(jwd3_q), .rule_i(fold_rule(edate_q)), .tod_i(etod_q),
    .off_i(doff_q), .inst_o(en_inst));

  logic signed [NowW-1:0] st_q, en5_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      now4_q <= now3_q;
      now5_q <= now4_q;
      st_q   <= st_inst;
      en5_q  <= en_inst;
    end
  end

  // compare at the output
  always_comb begin
    if (!en_q) out.data = StNoRule;
    else if (st_q < en5_q)
      out.data = (now5_q >= st_q && now5_q < en5_q) ? StActive : StInactive;
    else
      out.data = (now5_q >= en5_q && now5_q < st_q) ? StInactive : StActive;
  end

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out.valid && !out.ready |=> out.valid) else $error("item dropped");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[4] |-> in.ready) else $error("ready low with free slot");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in.valid && in.ready |=> v_q[0]) else $error("item not captured");
`endif
endmodule
